// ===== sv/mf3_pkg.sv =====
package mf3_pkg;

  // one color channel
  typedef logic [7:0] chan_t;

  // pixel, red in the lowest byte so it maps straight onto tdata
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  // entry of the output queue
  typedef struct packed {
    logic   last;
    pixel_t pix;
  } out_item_t;

  // register map, selected by paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int WIDTH_BITS   = 12;
  localparam int HEIGHT_BITS  = 13;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int HEIGHT_LIMIT = 4096;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

  localparam chan_t CHAN_MAX = 8'hFF;

endpackage

// ===== sv/mf3_median9.sv =====
module mf3_median9
  import mf3_pkg::*;
(
  input  logic [8:0][7:0] vals,
  output chan_t           med
);

  chan_t v [9];

  // compare-exchange: {min, max}
  function automatic logic [15:0] cx(input chan_t a, input chan_t b);
    cx = (a > b) ? {b, a} : {a, b};
  endfunction

  // 19-exchange median-of-nine network
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      v[i] = vals[i];
    end
    {v[1], v[2]} = cx(v[1], v[2]);
    {v[4], v[5]} = cx(v[4], v[5]);
    {v[7], v[8]} = cx(v[7], v[8]);
    {v[0], v[1]} = cx(v[0], v[1]);
    {v[3], v[4]} = cx(v[3], v[4]);
    {v[6], v[7]} = cx(v[6], v[7]);
    {v[1], v[2]} = cx(v[1], v[2]);
    {v[4], v[5]} = cx(v[4], v[5]);
    {v[7], v[8]} = cx(v[7], v[8]);
    {v[0], v[3]} = cx(v[0], v[3]);
    {v[5], v[8]} = cx(v[5], v[8]);
    {v[4], v[7]} = cx(v[4], v[7]);
    {v[3], v[6]} = cx(v[3], v[6]);
    {v[1], v[4]} = cx(v[1], v[4]);
    {v[2], v[5]} = cx(v[2], v[5]);
    {v[4], v[7]} = cx(v[4], v[7]);
    {v[4], v[2]} = cx(v[4], v[2]);
    {v[6], v[4]} = cx(v[6], v[4]);
    {v[4], v[2]} = cx(v[4], v[2]);
  end

  assign med = v[4];

endmodule

// ===== sv/median_filter_3x3_rgb.sv =====
// 3x3 per-channel median filter for an RGB pixel stream in raster order, one pixel per
// transaction on s_*. Each output pixel is the median of the neighbors that lie inside the
// image (border windows shrink), taken at sorted position count/2. Output trails input by
// one row plus one pixel; after the last pixel of a frame send image_width+1 transactions
// with s_tuser=1 to drain the rest, m_tlast marks the final pixel and the next transaction
// starts a new frame. Throughput is one pixel per clock while s_tready is high, set by the
// single-ported reads of the two line stores (MAX_WIDTH x 24 bits each); a pixel passes the
// first and second stage registers into the 4-entry output queue, which decouples m_tready;
// s_tready drops only at four results in queue and pipeline. No clearing pass after reset.
// Registers: 0x0 image_width (12 bits, reset 640), 0x4 image_height (13 bits, reset 480);
// width 0 acts as 1 and is capped at MAX_WIDTH, height 0 acts as 1 and is capped at 4096.
module median_filter_3x3_rgb
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic        clk,
  input  logic        rst,
  // pixel input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  input  logic        s_tuser,   // flush
  // filtered output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // red_out[7:0], green_out[15:8], blue_out[23:16]
  output logic        m_tlast,   // last_of_frame
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = HEIGHT_BITS;

  // configuration registers
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_BITS'(WIDTH_RESET);
      image_height <= HEIGHT_BITS'(HEIGHT_RESET);
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_BITS-1:0];
        default:          image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // effective frame size
  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [HW-1:0] h_p1;

  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == '0) begin
      h = HW'(1);
    end else if (int'(image_height) > HEIGHT_LIMIT) begin
      h = HW'(HEIGHT_LIMIT);
    end else begin
      h = image_height;
    end
    h_p1 = h + HW'(1);
  end

  // input position
  logic [CW-1:0] in_column, in_column_next;
  logic [HW-1:0] in_row, in_row_next;

  logic [CW-1:0] ca, cb;
  logic [HW-1:0] ra, rb;
  logic [WW-1:0] c_inc;
  logic          row_live, drop, cb_nz, have, last;
  pixel_t        px;
  logic [2:0]    rowv, colv;
  logic [8:0]    valid9;
  logic          accept, take;

  // position bookkeeping for the offered item
  always_comb begin
    if (WW'(in_column) >= w) begin
      ca = '0;
      ra = in_row + HW'(1);
    end else begin
      ca = in_column;
      ra = in_row;
    end
    if (ra > h_p1) begin
      cb = '0;
      rb = '0;
    end else begin
      cb = ca;
      rb = ra;
    end
    row_live = rb < h;
    drop     = row_live && s_tuser;
    px       = row_live ? pixel_t'(s_tdata) : '0;
    cb_nz    = cb != '0;
    have     = cb_nz ? (rb >= HW'(1) && rb <= h) : (rb >= HW'(2));
    last     = have && !cb_nz && rb == h_p1;

    c_inc = WW'(cb) + WW'(1);
    if (c_inc >= w) begin
      in_column_next = '0;
      in_row_next    = rb + HW'(1);
    end else begin
      in_column_next = c_inc[CW-1:0];
      in_row_next    = rb;
    end
    if (last) begin
      in_column_next = '0;
      in_row_next    = '0;
    end

    // neighbors inside the image, by window row and column
    if (cb_nz) begin
      rowv = {row_live, 1'b1, rb >= HW'(2)};
      colv = {1'b1, 1'b1, cb >= CW'(2)};
    end else begin
      rowv = {rb <= h, 1'b1, rb >= HW'(3)};
      colv = {1'b1, w >= WW'(2), 1'b0};
    end
    for (int i = 0; i < 9; i++) begin
      valid9[i] = rowv[i / 3] && colv[i % 3];
    end
  end

  assign accept = s_tvalid && s_tready;
  assign take   = accept && !drop;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (take) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
    end
  end

  // first stage registers
  logic          v1, have1, old1, last1;
  logic [8:0]    valid1;
  logic [CW-1:0] c1;
  pixel_t        px1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      have1 <= 1'b0;
    end else begin
      v1    <= take;
      have1 <= take && have;
    end
  end

  always_ff @(posedge clk) begin
    old1   <= !cb_nz;
    last1  <= last;
    valid1 <= valid9;
    c1     <= cb;
    px1    <= px;
  end

  // line stores
  pixel_t upper_mem [MAX_WIDTH];
  pixel_t middle_mem [MAX_WIDTH];
  pixel_t q_upper, q_middle;
  pixel_t above_now, mid_now;

  always_ff @(posedge clk) begin
    q_upper  <= upper_mem[cb];
    q_middle <= middle_mem[cb];
    if (v1) begin
      upper_mem[c1]  <= mid_now;
      middle_mem[c1] <= px1;
    end
  end

  // bypass when the next item reads the column being written (one-pixel rows)
  logic   fwd;
  pixel_t fwd_mid, fwd_px;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else begin
      fwd <= take && v1 && (cb == c1);
    end
  end

  always_ff @(posedge clk) begin
    fwd_mid <= mid_now;
    fwd_px  <= px1;
  end

  assign above_now = fwd ? fwd_mid : q_upper;
  assign mid_now   = fwd ? fwd_px : q_middle;

  // window shift and padding of outside neighbors
  pixel_t     win [9];
  pixel_t     new_win [9];
  pixel_t     src [9];
  pixel_t     padded [9];
  logic [3:0] n_valid, n_lo, k;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      new_win[r * 3]     = win[r * 3 + 1];
      new_win[r * 3 + 1] = win[r * 3 + 2];
    end
    new_win[2] = above_now;
    new_win[5] = mid_now;
    new_win[8] = px1;
    for (int i = 0; i < 9; i++) begin
      src[i] = old1 ? win[i] : new_win[i];
    end
    // outside slots: enough zeros below and maxima above to keep the median position
    n_valid = 4'($countones(valid1));
    n_lo    = 4'(4) - (n_valid >> 1);
    k       = '0;
    for (int i = 0; i < 9; i++) begin
      if (valid1[i]) begin
        padded[i] = src[i];
      end else begin
        padded[i] = (k < n_lo) ? '0 : {CHAN_MAX, CHAN_MAX, CHAN_MAX};
        k         = k + 4'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      win <= new_win;
    end
  end

  // second stage registers
  logic   have2, last2;
  pixel_t win2 [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      have2 <= 1'b0;
    end else begin
      have2 <= have1;
    end
  end

  always_ff @(posedge clk) begin
    last2 <= last1;
    win2  <= padded;
  end

  // per-channel medians
  logic [8:0][7:0] red_vals, green_vals, blue_vals;
  pixel_t          med;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      red_vals[i]   = win2[i].red;
      green_vals[i] = win2[i].green;
      blue_vals[i]  = win2[i].blue;
    end
  end

  mf3_median9 u_med_red   (.vals(red_vals),   .med(med.red));
  mf3_median9 u_med_green (.vals(green_vals), .med(med.green));
  mf3_median9 u_med_blue  (.vals(blue_vals),  .med(med.blue));

  // output queue
  out_item_t        fifo_mem [OUT_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;

  assign pop = m_tvalid && m_tready;

  always_comb begin
    count_next = count;
    if (have2 && !pop) begin
      count_next = count + CNT_W'(1);
    end else if (!have2 && pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (have2) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (have2) begin
      fifo_mem[wr_ptr] <= '{last: last2, pix: med};
    end
  end

  assign m_tvalid = count != '0;
  assign m_tdata  = fifo_mem[rd_ptr].pix;
  assign m_tlast  = fifo_mem[rd_ptr].last;

  // room for every result still in the pipeline
  assign s_tready = (count + CNT_W'(have1) + CNT_W'(have2)) < CNT_W'(OUT_DEPTH);

endmodule
